>>> design/wdsa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the wall detector.
`default_nettype none
package wdsa_pkg;

	// Item kinds carried in tuser bit 0
	localparam logic KIND_ACCUM = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_SIDE_THR        = 2'd0;
	localparam logic [1:0] REG_FRONT_SINGLE    = 2'd1;
	localparam logic [1:0] REG_FRONT_MEAN      = 2'd2;

	// Threshold reset values
	localparam logic [7:0] SIDE_THR_RST        = 8'd90;
	localparam logic [7:0] FRONT_SINGLE_RST    = 8'd80;
	localparam logic [7:0] FRONT_MEAN_RST      = 8'd100;

	// Side samples count only while the front sensors read above these
	localparam logic [7:0] FRONT_RIGHT_MIN     = 8'd20;
	localparam logic [7:0] FRONT_LEFT_MIN      = 8'd5;

	// Divider lanes, one per sensor sum
	localparam logic [1:0] LANE_FRONT_RIGHT    = 2'd0;
	localparam logic [1:0] LANE_FRONT_LEFT     = 2'd1;
	localparam logic [1:0] LANE_RIGHT          = 2'd2;
	localparam logic [1:0] LANE_LEFT           = 2'd3;

	// Quotient bits per average
	localparam int unsigned AVG_W              = 8;
	localparam logic [2:0] STEP_FIRST          = 3'd7;
	localparam logic [2:0] STEP_LAST           = 3'd0;

	// Controller commands to the datapath
	typedef struct packed {
		logic       item_load;   // capture the input beat
		logic       acc_apply;   // add the captured samples to the sums
		logic       div_load;    // load the divider with the sum of lane
		logic       div_step;    // run one quotient bit
		logic [1:0] lane;        // divider lane
		logic [2:0] step;        // quotient bit position
		logic       out_load;    // load the result register
		logic       out_eval;    // result is an evaluation, else all zero
		logic       clear;       // clear sums and counts
	} wdsa_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic kind;              // kind of the captured item
	} wdsa_sts_t;

endpackage
`default_nettype wire

>>> design/wdsa_ctrl.sv
// Controller state machine: item sequencing, shared divider schedule and output valid.
`default_nettype none
module wdsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output wdsa_pkg::wdsa_cmd_t     cmd,
	input  wire wdsa_pkg::wdsa_sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [1:0] lane_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic       out_free;
	logic       in_beat;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd           = '0;
		cmd.lane      = lane_q;
		cmd.step      = step_q;
		cmd.item_load = in_beat;
		state_nxt     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.kind == wdsa_pkg::KIND_EVAL) begin
					state_nxt = ST_LOAD;
				end else if (out_free) begin
					cmd.acc_apply = 1'b1;
					cmd.out_load  = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == wdsa_pkg::STEP_LAST) begin
					state_nxt = (lane_q == wdsa_pkg::LANE_LEFT) ? ST_FIN : ST_LOAD;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_eval = 1'b1;
					cmd.clear    = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Advance state, lane and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= wdsa_pkg::LANE_FRONT_RIGHT;
			step_q  <= wdsa_pkg::STEP_FIRST;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EXEC) begin
				lane_q <= wdsa_pkg::LANE_FRONT_RIGHT;
			end
			if (cmd.div_load) begin
				step_q <= wdsa_pkg::STEP_FIRST;
			end else if (cmd.div_step) begin
				step_q <= step_q - 3'd1;
				if (step_q == wdsa_pkg::STEP_LAST) begin
					lane_q <= lane_q + 2'd1;
				end
			end
		end
	end

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> design/wdsa_dp.sv
// Datapath: item register, running sums and counts, serial divider, thresholds and result.
`default_nettype none
module wdsa_dp #(
	parameter int unsigned MAX_SAMPLES = 65535
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wdsa_pkg::wdsa_cmd_t cmd,
	output wdsa_pkg::wdsa_sts_t     sts,
	input  wire logic [31:0]        s_tdata,
	input  wire logic [2:0]         s_tuser,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	output logic [7:0]              m_tdata,
	output logic [0:0]              m_tuser
);

	localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SumW = CntW + wdsa_pkg::AVG_W;
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_SAMPLES);

	// Captured item
	logic       kind_q;
	logic       sel_front_q;
	logic       sel_side_q;
	logic [7:0] d_fr_q;
	logic [7:0] d_r_q;
	logic [7:0] d_l_q;
	logic [7:0] d_fl_q;

	// Thresholds
	logic [7:0] side_thr_q;
	logic [7:0] front_single_q;
	logic [7:0] front_mean_q;

	// Sums and counts
	logic [SumW-1:0] sum_fr_q;
	logic [SumW-1:0] sum_fl_q;
	logic [SumW-1:0] sum_r_q;
	logic [SumW-1:0] sum_l_q;
	logic [CntW-1:0] front_cnt_q;
	logic [CntW-1:0] side_cnt_q;

	// Divider
	logic [SumW-1:0]            rem_q;
	logic [7:0]                 quo_q;
	logic [SumW-1:0]            div_sum;
	logic [CntW-1:0]            div_cnt;
	logic [SumW-1:0]            div_trial;
	logic                       div_ge;
	logic [7:0]                 quo_nxt;
	logic [3:0][7:0]            avg_q;

	// Result
	logic       front_take;
	logic       side_take;
	logic       wall_l;
	logic       wall_r;
	logic       wall_f;
	logic [8:0] front_pair;
	logic [7:0] front_mean;
	logic       one_close;
	logic [2:0] walls_q;
	logic       decided_q;

	assign sts.kind = kind_q;

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q      <= s_tuser[0];
			sel_front_q <= s_tuser[1];
			sel_side_q  <= s_tuser[2];
			d_fr_q      <= s_tdata[7:0];
			d_r_q       <= s_tdata[15:8];
			d_l_q       <= s_tdata[23:16];
			d_fl_q      <= s_tdata[31:24];
		end
	end

	// Write thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_thr_q     <= wdsa_pkg::SIDE_THR_RST;
			front_single_q <= wdsa_pkg::FRONT_SINGLE_RST;
			front_mean_q   <= wdsa_pkg::FRONT_MEAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wdsa_pkg::REG_SIDE_THR:     side_thr_q     <= cfg_data;
				wdsa_pkg::REG_FRONT_SINGLE: front_single_q <= cfg_data;
				wdsa_pkg::REG_FRONT_MEAN:   front_mean_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign front_take = sel_front_q && (front_cnt_q < CntMax);
	assign side_take  = sel_side_q && (d_fr_q > wdsa_pkg::FRONT_RIGHT_MIN)
		&& (d_fl_q > wdsa_pkg::FRONT_LEFT_MIN) && (side_cnt_q < CntMax);

	// Accumulate samples, clear on evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_fr_q    <= '0;
			sum_fl_q    <= '0;
			sum_r_q     <= '0;
			sum_l_q     <= '0;
			front_cnt_q <= '0;
			side_cnt_q  <= '0;
		end else if (cmd.clear) begin
			sum_fr_q    <= '0;
			sum_fl_q    <= '0;
			sum_r_q     <= '0;
			sum_l_q     <= '0;
			front_cnt_q <= '0;
			side_cnt_q  <= '0;
		end else if (cmd.acc_apply) begin
			if (front_take) begin
				sum_fr_q    <= sum_fr_q + SumW'(d_fr_q);
				sum_fl_q    <= sum_fl_q + SumW'(d_fl_q);
				front_cnt_q <= front_cnt_q + CntW'(1);
			end
			if (side_take) begin
				sum_r_q    <= sum_r_q + SumW'(d_r_q);
				sum_l_q    <= sum_l_q + SumW'(d_l_q);
				side_cnt_q <= side_cnt_q + CntW'(1);
			end
		end
	end

	// Select divider operands for the lane
	always_comb begin
		unique case (cmd.lane)
			wdsa_pkg::LANE_FRONT_RIGHT: div_sum = sum_fr_q;
			wdsa_pkg::LANE_FRONT_LEFT:  div_sum = sum_fl_q;
			wdsa_pkg::LANE_RIGHT:       div_sum = sum_r_q;
			default:                    div_sum = sum_l_q;
		endcase
		div_cnt = (cmd.lane == wdsa_pkg::LANE_FRONT_RIGHT ||
			cmd.lane == wdsa_pkg::LANE_FRONT_LEFT) ? front_cnt_q : side_cnt_q;
	end

	// One restoring step: the average is below 256, so eight quotient bits suffice
	assign div_trial = SumW'(div_cnt) << cmd.step;
	assign div_ge    = (rem_q >= div_trial);
	assign quo_nxt   = quo_q | (8'(div_ge) << cmd.step);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= div_sum;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= rem_q - div_trial;
			end
			quo_q <= quo_nxt;
			if (cmd.step == wdsa_pkg::STEP_LAST) begin
				avg_q[cmd.lane] <= quo_nxt;
			end
		end
	end

	// Compare averages with thresholds
	assign front_pair = {1'b0, avg_q[wdsa_pkg::LANE_FRONT_RIGHT]}
		+ {1'b0, avg_q[wdsa_pkg::LANE_FRONT_LEFT]};
	assign front_mean = front_pair[8:1];
	assign one_close  = (avg_q[wdsa_pkg::LANE_FRONT_RIGHT] < front_single_q)
		|| (avg_q[wdsa_pkg::LANE_FRONT_LEFT] < front_single_q);
	assign wall_l = (side_cnt_q != '0) && (avg_q[wdsa_pkg::LANE_LEFT] < side_thr_q);
	assign wall_r = (side_cnt_q != '0) && (avg_q[wdsa_pkg::LANE_RIGHT] < side_thr_q);
	assign wall_f = (front_cnt_q != '0) && one_close && (front_mean < front_mean_q);

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			decided_q <= cmd.out_eval;
			walls_q   <= cmd.out_eval ? {wall_f, wall_r, wall_l} : 3'b000;
		end
	end

	assign m_tdata = {5'b00000, walls_q};
	assign m_tuser = decided_q;

endmodule
`default_nettype wire

>>> design/wall_detect_by_sensor_average.sv
// Flow: an accumulate item is captured, then its samples are added and its result is
// loaded; an evaluate item runs four averages through one shared restoring divider at one
// quotient bit per cycle, each lane loaded and then stepped, before the result is loaded.
// Items: one at a time; the next is taken only once the last is done, and a result
// that waits on m_tready holds the next one back.
// Reset: arst_n clears sums, counts and control and loads the threshold defaults.
`default_nettype none
module wall_detect_by_sensor_average #(
	parameter int unsigned MAX_SAMPLES = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // dist_front_right, dist_right, dist_left, dist_front_left
	input  wire logic [2:0]  s_tuser,   // kind, select_front, select_side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // wall_left, wall_right, wall_front, zero fill
	output logic [0:0]       m_tuser,   // decided
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	wdsa_pkg::wdsa_cmd_t cmd;
	wdsa_pkg::wdsa_sts_t sts;

	// Take register writes at any time
	assign cfg_ready = 1'b1;

	wdsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	wdsa_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

>>> test/wall_verdict_check.sv
// Checker for the wall detector: watches all three channels, predicts each result and compares.
module wall_verdict_check #(
	parameter int unsigned MAX_SAMPLES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          pending,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import wdsa_pkg::*;

	typedef struct packed {
		logic decided;
		logic wall_left;
		logic wall_right;
		logic wall_front;
	} verdict_t;

	// Thresholds as last written
	logic [7:0] side_thr;
	logic [7:0] one_thr;
	logic [7:0] mean_thr;

	// Running sums and sample counts
	logic [23:0] sum_fr;
	logic [23:0] sum_fl;
	logic [23:0] sum_r;
	logic [23:0] sum_l;
	logic [15:0] front_n;
	logic [15:0] side_n;

	verdict_t verdicts_due[$];
	int errs = 0;

	// Advance the sums for one input beat and return the verdict it should produce
	function automatic verdict_t predict_verdict(input logic [2:0] user, input logic [31:0] data);
		verdict_t   v;
		logic [7:0] fr, r, l, fl;
		logic [7:0] avg_fr, avg_fl, avg_r, avg_l;
		logic [8:0] mean;
		v = '0;
		fr = data[7:0];
		r = data[15:8];
		l = data[23:16];
		fl = data[31:24];
		if (user[0] == KIND_ACCUM) begin
			if (user[1] && front_n < MAX_SAMPLES) begin
				sum_fr = sum_fr + 24'(fr);
				sum_fl = sum_fl + 24'(fl);
				front_n = front_n + 16'd1;
			end
			// side pair is taken only while both front sensors read clear
			if (user[2] && fr > FRONT_RIGHT_MIN && fl > FRONT_LEFT_MIN && side_n < MAX_SAMPLES) begin
				sum_r = sum_r + 24'(r);
				sum_l = sum_l + 24'(l);
				side_n = side_n + 16'd1;
			end
		end else begin
			v.decided = 1'b1;
			if (side_n != 0) begin
				avg_l = 8'(sum_l / side_n);
				avg_r = 8'(sum_r / side_n);
				v.wall_left = avg_l < side_thr;
				v.wall_right = avg_r < side_thr;
			end
			if (front_n != 0) begin
				avg_fr = 8'(sum_fr / front_n);
				avg_fl = 8'(sum_fl / front_n);
				mean = (9'(avg_fr) + 9'(avg_fl)) >> 1;
				v.wall_front = (avg_fr < one_thr || avg_fl < one_thr) && mean < 9'(mean_thr);
			end
			sum_fr = '0;
			sum_fl = '0;
			sum_r = '0;
			sum_l = '0;
			front_n = '0;
			side_n = '0;
		end
		return v;
	endfunction

	// Compare the result beat first, then take in configuration and input beats
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			side_thr = SIDE_THR_RST;
			one_thr = FRONT_SINGLE_RST;
			mean_thr = FRONT_MEAN_RST;
			sum_fr = '0;
			sum_fl = '0;
			sum_r = '0;
			sum_l = '0;
			front_n = '0;
			side_n = '0;
			verdicts_due.delete();
			pending <= 0;
			fail_count <= errs;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("result beat with nothing expected: decided=%0d walls=%b",
						m_tuser[0], m_tdata[2:0]);
					errs++;
				end else begin
					want = verdicts_due.pop_front();
					if (m_tuser[0] !== want.decided) begin
						$error("decided: expected %0d, actual %0d", want.decided, m_tuser[0]);
						errs++;
					end
					if (m_tdata[0] !== want.wall_left) begin
						$error("wall_left: expected %0d, actual %0d", want.wall_left, m_tdata[0]);
						errs++;
					end
					if (m_tdata[1] !== want.wall_right) begin
						$error("wall_right: expected %0d, actual %0d", want.wall_right, m_tdata[1]);
						errs++;
					end
					if (m_tdata[2] !== want.wall_front) begin
						$error("wall_front: expected %0d, actual %0d", want.wall_front, m_tdata[2]);
						errs++;
					end
					if (m_tdata[7:3] !== 5'd0) begin
						$error("zero fill: expected %0d, actual %0d", 0, m_tdata[7:3]);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SIDE_THR: side_thr = cfg_data;
					REG_FRONT_SINGLE: one_thr = cfg_data;
					REG_FRONT_MEAN: mean_thr = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				verdicts_due.push_back(predict_verdict(s_tuser, s_tdata));
			pending <= verdicts_due.size();
			fail_count <= errs;
		end
	end

endmodule

>>> test/testbench.sv
// Top of the wall detector bench: clock, reset, stimulus, back-pressure and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wdsa_pkg::*;

	// Sample cap of the block as specified
	localparam int unsigned SAMPLE_CAP = 65535;
	// Length that the long runs of samples are drawn around
	localparam int LONG_RUN = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 118;
	localparam int LONG_HOLD = 300;
	localparam int LONG_HOLD_AT = 250;
	localparam int LONG_HOLD_EVERY = 400;
	localparam int SETTLE = 40;
	localparam int unsigned RUN_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [31:0] s_tdata = '0;     // dist_front_right, dist_right, dist_left, dist_front_left
	logic [2:0]  s_tuser = '0;     // kind, select_front, select_side
	logic        m_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = REG_SIDE_THR;
	logic [7:0]  cfg_data = '0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [7:0]  m_tdata;          // wall_left, wall_right, wall_front, zero fill
	wire  [0:0]  m_tuser;          // decided
	wire         cfg_ready;
	int          pending;
	int          fail_count;

	// Thresholds currently loaded, used to aim sensor readings near the edges
	logic [7:0] cur_side = SIDE_THR_RST;
	logic [7:0] cur_one = FRONT_SINGLE_RST;
	logic [7:0] cur_mean = FRONT_MEAN_RST;

	int  tx_span = 0;
	bit  tx_calm = 1'b0;

	wall_detect_by_sensor_average #(.MAX_SAMPLES(SAMPLE_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	wall_verdict_check #(.MAX_SAMPLES(SAMPLE_CAP)) wall_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pending(pending), .fail_count(fail_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 45);
	endfunction

	// Spread a reading around a center value, clipped to the sensor range
	function automatic logic [7:0] near(input logic [7:0] center, input int spread);
		int v;
		v = int'(center) - spread + int'($urandom_range(0, 2 * spread));
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// Center either on a threshold or anywhere in range
	function automatic logic [7:0] pick_center(input logic [7:0] thr);
		if ($urandom_range(0, 2) == 0)
			return near(thr, 3);
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_threshold();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one beat after a random gap and hold it until taken
	task automatic send_item(input logic kind, input logic sel_front, input logic sel_side,
		input logic [7:0] fr, input logic [7:0] r, input logic [7:0] l, input logic [7:0] fl);
		int gap;
		if (tx_span == 0) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			tx_span = $urandom_range(10, 60);
		end else
			tx_span--;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {sel_side, sel_front, kind};
		s_tdata <= {fl, l, r, fr};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every expected result has been taken
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write all three thresholds back to back, holding valid across the beats
	task automatic load_thresholds(input logic [7:0] side, input logic [7:0] one,
		input logic [7:0] mean);
		logic [1:0] idx [3];
		logic [7:0] val [3];
		idx = '{REG_SIDE_THR, REG_FRONT_SINGLE, REG_FRONT_MEAN};
		val = '{side, one, mean};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_side = side;
		cur_one = one;
		cur_mean = mean;
	endtask

	// Edges of the gating, the thresholds and floor division at reset thresholds
	task automatic run_directed();
		send_item(KIND_EVAL, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_ACCUM, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
		send_item(KIND_ACCUM, 1'b0, 1'b1, 8'd20, 8'd0, 8'd0, 8'd255);
		send_item(KIND_ACCUM, 1'b0, 1'b1, 8'd255, 8'd0, 8'd0, 8'd5);
		send_item(KIND_ACCUM, 1'b1, 1'b1, 8'd21, 8'd0, 8'd255, 8'd6);
		send_item(KIND_EVAL, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
		send_item(KIND_ACCUM, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
		send_item(KIND_EVAL, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_ACCUM, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_EVAL, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_ACCUM, 1'b1, 1'b0, 8'd79, 8'd0, 8'd0, 8'd120);
		send_item(KIND_EVAL, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_ACCUM, 1'b1, 1'b0, 8'd80, 8'd0, 8'd0, 8'd120);
		send_item(KIND_EVAL, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_ACCUM, 1'b0, 1'b1, 8'd100, 8'd89, 8'd90, 8'd100);
		send_item(KIND_ACCUM, 1'b0, 1'b1, 8'd100, 8'd90, 8'd91, 8'd100);
		send_item(KIND_EVAL, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(KIND_ACCUM, 1'b1, 1'b0, 8'd200, 8'd0, 8'd0, 8'd0);
		send_item(KIND_EVAL, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	// Runs of samples around a scene, each closed by an evaluate, with some noise mixed in
	task automatic run_random(input int budget);
		int         left;
		int         run;
		int         spread;
		int         sel_rate;
		logic [7:0] c_fr, c_r, c_l, c_fl;
		left = budget;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0: run = 0;
				1, 2: run = $urandom_range(LONG_RUN - 5, LONG_RUN + 20);
				default: run = $urandom_range(1, 12);
			endcase
			if (run > left - 1)
				run = left - 1;
			sel_rate = (run >= LONG_RUN) ? 95 : 75;
			spread = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 6);
			c_fr = pick_center(cur_one);
			c_fl = pick_center(cur_one);
			c_r = pick_center(cur_side);
			c_l = pick_center(cur_side);
			for (int k = 0; k < run; k++) begin
				if ($urandom_range(0, 99) < 6)
					send_item(1'($urandom()), 1'($urandom()), 1'($urandom()),
						8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
				else
					send_item(KIND_ACCUM, $urandom_range(0, 99) < sel_rate,
						$urandom_range(0, 99) < sel_rate, near(c_fr, spread), near(c_r, spread),
						near(c_l, spread), near(c_fl, spread));
			end
			send_item(KIND_EVAL, 1'($urandom()), 1'($urandom()),
				8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
			left -= run + 1;
		end
	endtask

	// Take results with random stalls; hold off for a long stretch now and then
	initial begin : result_taker
		int hold = 0;
		int taken = 0;
		int span = 0;
		int next_long = LONG_HOLD_AT;
		bit calm = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				taken++;
			if (span == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				span = $urandom_range(20, 120);
			end else
				span--;
			if (hold == 0 && taken >= next_long) begin
				hold = LONG_HOLD;
				next_long += LONG_HOLD_EVERY;
			end else if (hold == 0 && !calm)
				hold = pick_gap();
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else
				m_tready <= 1'b1;
		end
	end

	// End the run if it stalls
	initial begin : watchdog
		int unsigned cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[wall_detect_by_sensor_average] ERROR");
		$finish;
	end

	// Reset, directed items, then random phases under changing thresholds
	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				load_thresholds(8'd255, 8'd255, 8'd255);
			else if (ph == 1)
				load_thresholds(8'd0, 8'd0, 8'd0);
			else if (ph == PHASES - 1)
				load_thresholds(SIDE_THR_RST, FRONT_SINGLE_RST, FRONT_MEAN_RST);
			else
				load_thresholds(pick_threshold(), pick_threshold(), pick_threshold());
			run_random(PHASE_ITEMS);
			wait_drained();
		end
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("[wall_detect_by_sensor_average] OK");
		else
			$display("[wall_detect_by_sensor_average] ERROR");
		$finish;
	end

endmodule
